// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes and the control/status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // payload field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int IDX_W  = 11;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;

   // operation codes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

   localparam int TAB_STOP = 8;

   // controller to datapath
   typedef struct packed {
      logic clear_step;     // write zero at sweep counter, advance it
      logic capture;        // register the accepted item
      logic exec;           // apply the registered put to cursor and store
      logic scroll_step;    // issue one scroll copy read, advance counter
      logic load_out;       // load the result register
      logic out_from_regs;  // result taken from cursor registers, scrolled set
      logic rd_from_port;   // store read address from the input channel
   } tcw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_last;       // sweep counter at last cell
      logic req_is_put;     // registered item is a put
      logic scroll_need;    // registered put runs past the last row
   } tcw_sts_type;

endpackage

// ----- design/tcw_if.sv -----
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for requests, responses and the attribute register.
// ----------------------------------------------------------------------------

// request channel
interface tcw_req_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [CHAR_W-1:0] ch;
   logic [IDX_W-1:0]  cell_index;

   modport source (output valid, op, ch, cell_index, input ready);
   modport sink   (input valid, op, ch, cell_index, output ready);
endinterface

// response channel
interface tcw_rsp_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic [IDX_W-1:0]  cursor_pos;
   logic              scrolled;
   logic [CHAR_W-1:0] read_char;
   logic [ATTR_W-1:0] read_attr;

   modport source (output valid, cursor_col, cursor_row, cursor_pos, scrolled,
                   read_char, read_attr, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_pos, scrolled,
                   read_char, read_attr, output ready);
endinterface

// attribute register write channel
interface tcw_csr_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- design/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the clearing pass, put/read execution, scroll copy and the
// result register handshake.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  tcw_sts_type sts,
   output tcw_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_TAIL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new item this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.rd_from_port = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               if (sts.req_is_put && sts.scroll_need) begin
                  state_in = ST_SCROLL;
               end else begin
                  cmd.load_out = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // last copy write drains
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.out_from_regs = 1'b1;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/tcw_dpath.sv -----
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cursor and attribute registers, cell store, scroll copy pipeline and the
// result register.
// ----------------------------------------------------------------------------
module tcw_dpath import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  tcw_cmd_type       cmd,
   output tcw_sts_type       sts,
   // request payload
   input  logic              req_op,
   input  logic [CHAR_W-1:0] req_ch,
   input  logic [IDX_W-1:0]  req_cell_index,
   // attribute write
   input  logic              csr_valid,
   input  logic [ATTR_W-1:0] csr_data,
   // result payload
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [IDX_W-1:0]  rsp_cursor_pos,
   output logic              rsp_scrolled,
   output logic [CHAR_W-1:0] rsp_read_char,
   output logic [ATTR_W-1:0] rsp_read_attr
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int KEEP   = CELLS - COLUMNS;
   localparam int AW     = $clog2(CELLS);
   localparam int CRW    = $clog2(COLUMNS);
   localparam int RRW    = $clog2(ROWS);
   localparam int CTW    = $clog2(COLUMNS + TAB_STOP);
   localparam int RTW    = $clog2(ROWS + 1);
   localparam int CELL_W = CHAR_W + ATTR_W;

   // registers
   logic [ATTR_W-1:0] attr_ff;
   logic [CRW-1:0]    col_ff;
   logic [RRW-1:0]    row_ff;
   logic              op_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              sc_vld_ff;
   logic [AW-1:0]     sc_addr_ff;
   logic              sc_keep_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [IDX_W-1:0]  out_pos_ff;
   logic              out_scr_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic [ATTR_W-1:0] out_attr_ff;

   // combinational
   logic [CTW-1:0]    col_t;
   logic [RTW-1:0]    row_t;
   logic              wr_cell;
   logic              scroll_need;
   logic [CRW-1:0]    col_nxt;
   logic [RRW-1:0]    row_nxt;
   logic [AW-1:0]     cur_addr;
   logic [CRW-1:0]    col_sel;
   logic [RRW-1:0]    row_sel;
   logic [AW-1:0]     pos_sel;
   logic              is_put;
   logic              idx_ok;
   logic              cnt_last;
   logic              keep_now;
   logic              ram_we;
   logic [AW-1:0]     ram_wa;
   logic [CELL_W-1:0] ram_wd;
   logic [AW-1:0]     ram_ra;
   logic [CELL_W-1:0] ram_rd;

   assign is_put   = (op_ff == OP_PUT);
   assign idx_ok   = (32'(idx_ff) < CELLS);
   assign cnt_last = (cnt_ff == AW'(CELLS - 1));
   assign keep_now = (32'(cnt_ff) < KEEP);

   // cursor movement for the registered put
   always_comb begin
      col_t   = CTW'(col_ff);
      row_t   = RTW'(row_ff);
      wr_cell = 1'b0;
      case (ch_ff)
         CH_NEWLINE: begin
            col_t = '0;
            row_t = RTW'(row_ff) + RTW'(1);
         end
         CH_TAB: begin
            // round up to next tab stop
            col_t = (CTW'(col_ff) | CTW'(TAB_STOP - 1)) + CTW'(1);
         end
         CH_RETURN: begin
            col_t = '0;
         end
         CH_BACKSPACE: begin
            if (col_ff != '0) begin
               col_t = CTW'(col_ff) - CTW'(1);
            end
         end
         default: begin
            col_t   = CTW'(col_ff) + CTW'(1);
            wr_cell = 1'b1;
         end
      endcase
      // wrap into next row
      if (col_t >= CTW'(COLUMNS)) begin
         col_t = col_t - CTW'(COLUMNS);
         row_t = row_t + RTW'(1);
      end
      scroll_need = (row_t >= RTW'(ROWS));
      col_nxt     = CRW'(col_t);
      row_nxt     = scroll_need ? RRW'(ROWS - 1) : RRW'(row_t);
   end

   // cell under the cursor
   assign cur_addr = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);

   // cursor reported in the result
   always_comb begin
      if (is_put && !cmd.out_from_regs) begin
         col_sel = col_nxt;
         row_sel = row_nxt;
      end else begin
         col_sel = col_ff;
         row_sel = row_ff;
      end
      pos_sel = AW'(row_sel) * AW'(COLUMNS) + AW'(col_sel);
   end

   // store write port: clearing, scroll copy, printed character
   always_comb begin
      ram_we = 1'b0;
      ram_wa = cur_addr;
      ram_wd = {attr_ff, ch_ff};
      if (cmd.clear_step) begin
         ram_we = 1'b1;
         ram_wa = cnt_ff;
         ram_wd = '0;
      end else if (sc_vld_ff) begin
         ram_we = 1'b1;
         ram_wa = sc_addr_ff;
         ram_wd = sc_keep_ff ? ram_rd : '0;
      end else if (cmd.exec && is_put && wr_cell) begin
         ram_we = 1'b1;
      end
   end

   // store read port
   always_comb begin
      if (cmd.scroll_step) begin
         ram_ra = keep_now ? (cnt_ff + AW'(COLUMNS)) : cnt_ff;
      end else if (cmd.rd_from_port) begin
         ram_ra = AW'(req_cell_index);
      end else begin
         ram_ra = AW'(idx_ff);
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // sweep counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_step || cmd.scroll_step) begin
         cnt_in = cnt_last ? '0 : (cnt_ff + AW'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff   <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         cnt_ff    <= '0;
         sc_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
         if (cmd.exec && is_put) begin
            col_ff <= col_nxt;
            row_ff <= row_nxt;
         end
         cnt_ff    <= cnt_in;
         sc_vld_ff <= cmd.scroll_step;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         ch_ff  <= req_ch;
         idx_ff <= req_cell_index;
      end
      // scroll copy write stage, in the cycle after its read
      sc_addr_ff <= cnt_ff;
      sc_keep_ff <= keep_now;
      if (cmd.load_out) begin
         out_col_ff  <= COL_W'(col_sel);
         out_row_ff  <= ROW_W'(row_sel);
         out_pos_ff  <= IDX_W'(pos_sel);
         out_scr_ff  <= cmd.out_from_regs;
         out_char_ff <= (!is_put && idx_ok) ? ram_rd[CHAR_W-1:0] : '0;
         out_attr_ff <= (!is_put && idx_ok) ? ram_rd[CELL_W-1:CHAR_W] : '0;
      end
   end

   assign sts.cnt_last    = cnt_last;
   assign sts.req_is_put  = is_put;
   assign sts.scroll_need = scroll_need;

   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cursor_pos = out_pos_ff;
   assign rsp_scrolled   = out_scr_ff;
   assign rsp_read_char  = out_char_ff;
   assign rsp_read_attr  = out_attr_ff;

endmodule

// ----- design/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console: puts bytes at a cursor, handles control codes,
// wraps and scrolls, and reads back single cells.
//
//   channel  direction  handshake         carries
//   req_bus  in         valid / ready     op, ch, cell_index
//   rsp_bus  out        valid / ready     cursor_col/row/pos, scrolled,
//                                         read_char, read_attr
//   csr_bus  in         valid / ready=1   data (text attribute)
//
// Put without scroll and read: accept, then execute; a new item is accepted
// only once the last one is executed. Put that scrolls: accept, execute,
// scroll copy, drain and finish; the scroll copy moves one cell per cycle
// through the single write port of the cell store. After reset a clearing
// pass writes zero to all COLUMNS*ROWS cells, one per cycle; req_bus.ready
// stays low meanwhile. The result register lets an item be accepted while
// the previous result waits; execution then holds until that result is taken.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_bus,
   tcw_rsp_if.source rsp_bus,
   tcw_csr_if.sink   csr_bus
);

   tcw_cmd_type cmd;
   tcw_sts_type sts;

   // attribute writes are always taken
   assign csr_bus.ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_bus.op),
      .req_ch         (req_bus.ch),
      .req_cell_index (req_bus.cell_index),
      .csr_valid      (csr_bus.valid),
      .csr_data       (csr_bus.data),
      .rsp_cursor_col (rsp_bus.cursor_col),
      .rsp_cursor_row (rsp_bus.cursor_row),
      .rsp_cursor_pos (rsp_bus.cursor_pos),
      .rsp_scrolled   (rsp_bus.scrolled),
      .rsp_read_char  (rsp_bus.read_char),
      .rsp_read_attr  (rsp_bus.read_attr)
   );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put and read items on the request channel and keeps a shadow copy of
// the cell store, cursor and text attribute to predict every response. Each
// response is checked field by field against the oldest prediction. Both
// channels idle at random. The response side holds off once for a long
// stretch. The attribute changes between phases. One phase is newline heavy
// so that the console scrolls again and again.
// ----------------------------------------------------------------------------
module tb;
   import tcw_pkg::*;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int CELLS        = COLUMNS * ROWS;
   localparam int IDX_TOP      = (1 << IDX_W) - 1;
   localparam int IDLE_PCT     = 27;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 190;
   localparam int HEAVY_PHASE  = 3;
   localparam int RAND_PHASE   = 5;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 100;
   localparam int CALM_LO      = 600;
   localparam int CALM_HI      = 800;
   localparam int DRAIN_CYCLES = 40;

   // one response as seen on the response channel
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [IDX_W-1:0]  pos;
      logic              scrolled;
      logic [CHAR_W-1:0] rchar;
      logic [ATTR_W-1:0] rattr;
   } cursor_report_type;

   // one directed item; want is used only when typed is set
   typedef struct packed {
      logic              op;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      logic              typed;
      cursor_report_type want;
   } console_cmd_type;

   // directed items, run with the attribute at zero right after reset
   localparam console_cmd_type DIRECTED [25] = '{
      // cleared store, cursor at home
      '{OP_READ, 8'h00, 11'd0,    1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      // index past the store, top of the field and first one past the end, then the last cell
      '{OP_READ, 8'h00, 11'd2047, 1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      '{OP_READ, 8'h00, 11'd2000, 1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      '{OP_READ, 8'h00, 11'd1999, 1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      // printable, top and bottom byte values
      '{OP_PUT,  8'h41, 11'd0,    1'b1, '{7'd1, 5'd0, 11'd1, 1'b0, 8'h00, 8'h00}},
      '{OP_PUT,  8'hFF, 11'd0,    1'b1, '{7'd2, 5'd0, 11'd2, 1'b0, 8'h00, 8'h00}},
      '{OP_PUT,  8'h00, 11'd0,    1'b1, '{7'd3, 5'd0, 11'd3, 1'b0, 8'h00, 8'h00}},
      '{OP_PUT, CH_BACKSPACE, 11'd0, 1'b1, '{7'd2, 5'd0, 11'd2, 1'b0, 8'h00, 8'h00}},
      '{OP_PUT, CH_RETURN,    11'd0, 1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      // backspace stops at column zero
      '{OP_PUT, CH_BACKSPACE, 11'd0, 1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h00, 8'h00}},
      // backspace does not erase
      '{OP_READ, 8'h00, 11'd0,    1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'h41, 8'h00}},
      '{OP_READ, 8'h00, 11'd1,    1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 8'hFF, 8'h00}},
      '{OP_PUT, CH_TAB,       11'd0, 1'b1, '{7'd8, 5'd0, 11'd8, 1'b0, 8'h00, 8'h00}},
      '{OP_PUT,  8'h7E, 11'd0,    1'b0, '0},
      '{OP_PUT, CH_NEWLINE,   11'd0, 1'b1, '{7'd0, 5'd1, 11'd80, 1'b0, 8'h00, 8'h00}},
      // tabs across row one; the last one wraps to the next row
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB, 11'd0, 1'b0, '0},
      '{OP_PUT, CH_TAB,       11'd0, 1'b1, '{7'd0, 5'd2, 11'd160, 1'b0, 8'h00, 8'h00}}
   };

   localparam logic [ATTR_W-1:0] PHASE_ATTR [PHASES] = '{
      8'hFF, 8'h3C, 8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF
   };

   logic clock;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow console
   logic [15:0]       shadow_cells [CELLS];
   int unsigned       shadow_col;
   int unsigned       shadow_row;
   logic [ATTR_W-1:0] shadow_attr;

   cursor_report_type pending_reports [$];
   int                mismatches   = 0;
   int                items_sent   = 0;
   int                reports_seen = 0;

   // apply one item to the shadow console and return the response it gives
   function automatic cursor_report_type console_step(logic op, logic [CHAR_W-1:0] ch,
                                                     logic [IDX_W-1:0] idx);
      cursor_report_type r;
      logic              moved_up;
      r        = '0;
      moved_up = 1'b0;
      if (op == OP_PUT) begin
         case (ch)
            CH_NEWLINE: begin
               shadow_col = 0;
               shadow_row++;
            end
            CH_TAB:       shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
            CH_RETURN:    shadow_col = 0;
            CH_BACKSPACE: if (shadow_col > 0) shadow_col--;
            default: begin
               shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
               shadow_col++;
            end
         endcase
         // wrap past the last column
         if (shadow_col >= COLUMNS) begin
            shadow_col -= COLUMNS;
            shadow_row++;
         end
         // scroll up one row, bottom row blank
         if (shadow_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_cells[i] = '0;
            shadow_row = ROWS - 1;
            moved_up   = 1'b1;
         end
      end else if (int'(idx) < CELLS) begin
         r.rchar = shadow_cells[idx][7:0];
         r.rattr = shadow_cells[idx][15:8];
      end
      r.col      = COL_W'(shadow_col);
      r.row      = ROW_W'(shadow_row);
      r.pos      = IDX_W'(shadow_row * COLUMNS + shadow_col);
      r.scrolled = moved_up;
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // attribute write; called and returns at a falling edge
   task automatic write_attribute(logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      shadow_attr = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // offer one request item; called and returns at a falling edge, valid left high
   task automatic offer_item(logic op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx,
                             logic typed, cursor_report_type want);
      cursor_report_type predicted;
      while (!(items_sent >= CALM_LO && items_sent < CALM_HI)
             && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.ch         <= ch;
      req_bus.cell_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = console_step(op, ch, idx);
      pending_reports.push_back(typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // request stimulus
   initial begin
      logic              op;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      logic [ATTR_W-1:0] attr;
      int                roll;
      int                sel;
      int                nl_pct;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_PUT;
      req_bus.ch         = '0;
      req_bus.cell_index = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.data       = '0;
      reset              = 1'b1;
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      shadow_col  = 0;
      shadow_row  = 0;
      shadow_attr = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed items
      write_attribute(8'h00);
      foreach (DIRECTED[i])
         offer_item(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].idx,
                    DIRECTED[i].typed, DIRECTED[i].want);

      // random phases, attribute changed only with the block drained
      for (int p = 0; p < PHASES; p++) begin
         req_bus.valid <= 1'b0;
         while (pending_reports.size() != 0) @(posedge clock);
         attr = (p == RAND_PHASE) ? ATTR_W'($urandom_range(0, 255)) : PHASE_ATTR[p];
         write_attribute(attr);
         nl_pct = (p == HEAVY_PHASE) ? 30 : 4;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
               // reads near the cursor half the time, some past the store, the rest anywhere
               op  = OP_READ;
               ch  = CHAR_W'($urandom_range(0, 255));
               sel = $urandom_range(0, 9);
               if (sel < 3)
                  idx = IDX_W'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
               else if (sel < 5)
                  idx = IDX_W'((shadow_row > 0 ? shadow_row - 1 : 0) * COLUMNS
                               + $urandom_range(0, COLUMNS - 1));
               else if (sel < 6)
                  idx = IDX_W'($urandom_range(CELLS, IDX_TOP));
               else
                  idx = IDX_W'($urandom_range(0, IDX_TOP));
            end else begin
               op   = OP_PUT;
               idx  = IDX_W'($urandom_range(0, IDX_TOP));
               roll = $urandom_range(0, 99);
               if (roll < nl_pct)           ch = CH_NEWLINE;
               else if (roll < nl_pct + 4)  ch = CH_TAB;
               else if (roll < nl_pct + 7)  ch = CH_RETURN;
               else if (roll < nl_pct + 12) ch = CH_BACKSPACE;
               else                         ch = CHAR_W'($urandom_range(0, 255));
            end
            offer_item(op, ch, idx, 1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      // drain, then watch for stray responses
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // response ready: random gaps, one long hold-off, one calm stretch
   initial begin
      int hold_left;
      bit held;
      hold_left     = 0;
      held          = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held && reports_seen >= HOLD_AT) begin
            held          = 1'b1;
            hold_left     = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (reports_seen >= CALM_LO && reports_seen < CALM_HI) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task automatic compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      end
   endtask

   // response checking
   always @(posedge clock) begin : check_reports
      cursor_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing pending, expected none got col %0d row %0d",
                     $time, rsp_bus.cursor_col, rsp_bus.cursor_row);
         end else begin
            want = pending_reports.pop_front();
            compare_field("cursor_col", 16'(want.col),      16'(rsp_bus.cursor_col));
            compare_field("cursor_row", 16'(want.row),      16'(rsp_bus.cursor_row));
            compare_field("cursor_pos", 16'(want.pos),      16'(rsp_bus.cursor_pos));
            compare_field("scrolled",   16'(want.scrolled), 16'(rsp_bus.scrolled));
            compare_field("read_char",  16'(want.rchar),    16'(rsp_bus.read_char));
            compare_field("read_attr",  16'(want.rattr),    16'(rsp_bus.read_attr));
         end
      end
   end

   // run limit, far beyond a run where every put scrolls
   initial begin
      #200_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
